// ===== rtl/dbm_pkg.sv =====
// Shared types and helpers for the dual-channel block median filter.
package dbm_pkg;

    localparam int SAMPLE_W = 24;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // What one sorting cell hands to the next one up the row.
    typedef struct packed {
        logic    valid;   // cell holds an entry of the current window
        logic    gt;      // cell value is above the incoming word (or cell empty)
        t_sample value;
    } t_link;

    // Floored mean of two samples: widen by one bit, add, arithmetic shift.
    function automatic t_sample floor_mean(input t_sample lo, input t_sample hi);
        logic signed [SAMPLE_W:0] sum;
        begin
            sum = {lo[SAMPLE_W-1], lo} + {hi[SAMPLE_W-1], hi};
            floor_mean = t_sample'(sum >>> 1);
        end
    endfunction

endpackage

// ===== rtl/dual_block_median.sv =====
// Top level: paired block median filter over two sensor channels.
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  ------------------------------
//  input     i_short_sample, i_long_sample           word taken when start && !busy
//  result    o_short_med, o_long_med                 o_valid, one cycle, no stall
//
// One word is taken every cycle; busy stays low. Each word is sorted into
// a row of WINDOW_SIZE cells per channel in the cycle it arrives. The word
// that fills a window raises o_valid after the median pick (r_done) and the
// output register. Reset (i_rst_n, synchronous) empties the rows and the
// fill counter. The receiver cannot stall the result.
module dual_block_median
    import dbm_pkg::*;
#(
    parameter int WINDOW_SIZE = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_sample i_short_sample,
    input  t_sample i_long_sample,
    output logic    o_valid,
    output t_sample o_short_med,
    output t_sample o_long_med
);

    localparam int CNT_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int MID   = WINDOW_SIZE / 2;

    logic             accept;
    logic             last;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_done;
    logic             r_strobe;
    t_sample          r_short_med;
    t_sample          r_long_med;
    t_sample          short_taps [WINDOW_SIZE];
    t_sample          long_taps  [WINDOW_SIZE];
    t_sample          short_mid;
    t_sample          long_mid;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign last   = accept && (r_count == CNT_W'(WINDOW_SIZE - 1));

    always_comb begin
        n_count = r_count;
        if (last) begin
            n_count = '0;
        end else if (accept) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    dbm_chain #(.WINDOW_SIZE(WINDOW_SIZE)) u_short (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ins   (accept),
        .i_clr   (r_done),
        .i_word  (i_short_sample),
        .o_taps  (short_taps)
    );

    dbm_chain #(.WINDOW_SIZE(WINDOW_SIZE)) u_long (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ins   (accept),
        .i_clr   (r_done),
        .i_word  (i_long_sample),
        .o_taps  (long_taps)
    );

    // Rows are fully sorted in the cycle after the last word; read the middle.
    if ((WINDOW_SIZE % 2) == 1) begin : g_odd
        assign short_mid = short_taps[MID];
        assign long_mid  = long_taps[MID];
    end else begin : g_even
        assign short_mid = floor_mean(short_taps[MID-1], short_taps[MID]);
        assign long_mid  = floor_mean(long_taps[MID-1], long_taps[MID]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_done   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_done   <= last;
            r_strobe <= r_done;
        end
        if (r_done) begin
            r_short_med <= short_mid;
            r_long_med  <= long_mid;
        end
    end

    assign o_valid     = r_strobe;
    assign o_short_med = r_short_med;
    assign o_long_med  = r_long_med;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(WINDOW_SIZE - 1))
        else $error("fill counter beyond window");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last |=> r_done)
        else $error("window fill not flagged");

    a_strobe_follows_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> o_valid)
        else $error("median word not issued");

    a_strobe_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_done))
        else $error("median word without full window");

endmodule

// ===== rtl/dbm_cell.sv =====
// One insertion-sort cell: holds one sorted entry and its valid bit.
module dbm_cell
    import dbm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_ins,
    input  logic    i_clr,
    input  t_sample i_word,
    input  t_link   i_prev,
    output t_link   o_link
);

    logic    r_valid;
    logic    n_valid;
    t_sample r_value;
    t_sample n_value;
    logic    eff_valid;
    logic    gt;

    // i_clr empties the row for a new window; an insert in that same cycle
    // lands in an empty row.
    always_comb begin
        eff_valid = r_valid && !i_clr;
        gt        = !eff_valid || (r_value > i_word);
        n_valid   = eff_valid;
        n_value   = r_value;
        if (i_ins) begin
            n_valid = i_prev.valid;
            if (gt) begin
                n_value = i_prev.gt ? i_prev.value : i_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
    end

    assign o_link = '{valid: eff_valid, gt: gt, value: r_value};

endmodule

// ===== rtl/dbm_chain.sv =====
// Row of sorting cells for one channel; keeps the window in ascending order.
module dbm_chain
    import dbm_pkg::*;
#(
    parameter int WINDOW_SIZE = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_ins,
    input  logic    i_clr,
    input  t_sample i_word,
    output t_sample o_taps [WINDOW_SIZE]
);

    t_link links [WINDOW_SIZE+1];

    // Bottom of the row: always "occupied", never above the word.
    assign links[0] = '{valid: 1'b1, gt: 1'b0, value: '0};

    for (genvar g = 0; g < WINDOW_SIZE; g++) begin : g_cell
        dbm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ins   (i_ins),
            .i_clr   (i_clr),
            .i_word  (i_word),
            .i_prev  (links[g]),
            .o_link  (links[g+1])
        );
        assign o_taps[g] = links[g+1].value;
    end

endmodule

// ===== test/dual_block_median_tb.sv =====
// Testbench for dual_block_median: scoreboard-checked directed and random sample pairs.
`timescale 1ns / 1ps

module dual_block_median_tb;
    import dbm_pkg::*;

    localparam int     WIN         = 8;
    localparam int     RAND_WORDS  = 1300;
    localparam t_sample S_MAX      = 24'h7FFFFF;
    localparam t_sample S_MIN      = 24'h800000;

    logic    i_clk;
    logic    i_rst_n        = 1'b0;
    logic    start          = 1'b0;
    logic    busy;
    t_sample i_short_sample = '0;
    t_sample i_long_sample  = '0;
    logic    o_valid;
    t_sample o_short_med;
    t_sample o_long_med;

    dual_block_median #(.WINDOW_SIZE(WIN)) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_short_sample (i_short_sample),
        .i_long_sample  (i_long_sample),
        .o_valid        (o_valid),
        .o_short_med    (o_short_med),
        .o_long_med     (o_long_med)
    );

    class median_scoreboard;
        t_sample short_win [WIN];
        t_sample long_win  [WIN];
        int      fill_count;
        t_sample short_due [$];
        t_sample long_due  [$];
        int      errors;

        function new();
            fill_count = 0;
            errors     = 0;
        endfunction

        function t_sample window_median(input t_sample win [WIN]);
            t_sample                 ordered [WIN];
            t_sample                 key;
            logic signed [SAMPLE_W:0] total;
            int                      j;
            ordered = win;
            for (int i = 1; i < WIN; i++) begin
                key = ordered[i];
                j   = i - 1;
                while (j >= 0 && ordered[j] > key) begin
                    ordered[j+1] = ordered[j];
                    j--;
                end
                ordered[j+1] = key;
            end
            if (WIN % 2 == 1)
                return ordered[WIN/2];
            // even window: floored mean of the two middle entries
            total = ordered[WIN/2-1];
            total = total + ordered[WIN/2];
            return total[SAMPLE_W:1];
        endfunction

        function void note_word(input t_sample s, input t_sample l);
            short_win[fill_count] = s;
            long_win[fill_count]  = l;
            fill_count++;
            if (fill_count == WIN) begin
                short_due.push_back(window_median(short_win));
                long_due.push_back(window_median(long_win));
                fill_count = 0;
            end
        endfunction

        task report(input string msg);
            $display("%0t ns: MISMATCH %s", $realtime, msg);
            errors++;
        endtask

        task check_result(input t_sample s, input t_sample l);
            t_sample want_s;
            t_sample want_l;
            if (short_due.size() == 0) begin
                report($sformatf("result with none pending: short %0d long %0d", s, l));
            end else begin
                want_s = short_due.pop_front();
                want_l = long_due.pop_front();
                if (s !== want_s)
                    report($sformatf("short med %0d, want %0d", s, want_s));
                if (l !== want_l)
                    report($sformatf("long med %0d, want %0d", l, want_l));
            end
        endtask

        function int pending();
            return short_due.size();
        endfunction
    endclass

    median_scoreboard sb = new();

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watch both sides on the edge that takes the word / result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_word(i_short_sample, i_long_sample);
            if (o_valid)
                sb.check_result(o_short_med, o_long_med);
        end
    end

    function t_sample rand_sample();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? S_MAX : S_MIN;
            1, 2:    return t_sample'($signed($urandom_range(0, 8)) - 4);
            default: return t_sample'($urandom);
        endcase
    endfunction

    // call at a rising edge; returns at the edge that takes the word
    task send_word(input t_sample s, input t_sample l);
        start          <= 1'b1;
        i_short_sample <= s;
        i_long_sample  <= l;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task idle(input int cycles);
        start          <= 1'b0;
        i_short_sample <= t_sample'($urandom);
        i_long_sample  <= t_sample'($urandom);
        repeat (cycles) @(posedge i_clk);
    endtask

    task drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    int dir_short [24] = '{
        S_MAX, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN, S_MIN,
        S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN,
        -1, 0, -1, 0, -1, 0, -3, 5
    };
    int dir_long [24] = '{
        7, 6, 5, 4, 3, 2, 1, 0,
        S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX,
        1, -2, 3, -4, 5, -6, 7, -8
    };

    initial begin
        int sent;
        int burst;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, descending order, ties, negative odd sums
        foreach (dir_short[k])
            send_word(t_sample'(dir_short[k]), t_sample'(dir_long[k]));
        drain();
        idle(3);

        sent = 0;
        while (sent < RAND_WORDS) begin
            burst = $urandom_range(1, 48);
            for (int b = 0; b < burst && sent < RAND_WORDS; b++) begin
                send_word(rand_sample(), rand_sample());
                sent++;
            end
            case ($urandom_range(0, 7))
                0, 1: ;
                2:       if ($urandom_range(0, 3) == 0) drain(); else idle(1);
                default: idle($urandom_range(1, 6));
            endcase
        end

        drain();
        repeat (WIN + 8) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
